// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DHT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DHT_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define DHT_ASSERT(lbl, clk, rst, prop, msg)
`define DHT_ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/core/dht_pkg.sv =====
package dht_pkg;

   localparam int TABLE_SIZE  = 127;
   localparam int SLOT_W      = 8;
   localparam int KEY_W       = 31;
   localparam int PAY_W       = 64;
   localparam int IDX_W       = $clog2(TABLE_SIZE);
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_FULL     = 3'd1,
      STATUS_ZERO     = 3'd2,
      STATUS_READ     = 3'd3,
      STATUS_RANGE    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_ZERO   = 2'd1,
      KIND_READ   = 2'd2,
      KIND_RANGE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic              action;
      logic [KEY_W-1:0]  key;
      logic [PAY_W-1:0]  payload;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  read_key;
      logic [PAY_W-1:0]  read_payload;
      logic [SLOT_W-1:0] entry_count;
   } rsp_type;

   // classified work handed from front to back; slot is home slot or read index
   typedef struct packed {
      kind_type          kind;
      logic [KEY_W-1:0]  key;
      logic [PAY_W-1:0]  payload;
      logic [SLOT_W-1:0] slot;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   // v mod TABLE_SIZE for v below 16*TABLE_SIZE
   function automatic logic [SLOT_W-1:0] mod_table(input logic [13:0] v);
      logic [13:0] r;
      r = v;
      for (int i = 3; i >= 0; i--) begin
         if (r >= (14'(TABLE_SIZE) << i)) r = r - (14'(TABLE_SIZE) << i);
      end
      return r[SLOT_W-1:0];
   endfunction

   // v mod (TABLE_SIZE-1) for v below 32*(TABLE_SIZE-1)
   function automatic logic [SLOT_W-1:0] mod_step(input logic [13:0] v);
      logic [13:0] r;
      r = v;
      for (int i = 4; i >= 0; i--) begin
         if (r >= (14'(TABLE_SIZE - 1) << i)) r = r - (14'(TABLE_SIZE - 1) << i);
      end
      return r[SLOT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/double_hash_table_insert_top.sv =====
// Double-hashed table of nonzero 31-bit keys with 64-bit payloads.
// Request: drive req_item and raise start; a transfer happens at the edge
// where start is high and busy is low. action 0 inserts, action 1 reads a
// 0-based slot. Each request gives exactly one result on rsp_item, marked by
// rsp_valid for a single cycle; the receiver cannot hold it off.
// Requests are classified and hashed up front (one decimal digit per cycle
// through a reciprocal divide, up to 10 digits), then pass a two-entry queue
// to the probe engine, which steps each probe through a wait and a check
// state around the registered table read port.
// Zero keys and range errors are answered without probing, a read takes one
// table read, an insert on a full table is refused once hashed, and any
// other insert probes up to 127 slots; an item may also wait in the queue
// behind earlier work.
// Busy holds while a key is being hashed or the queue is full; a new request
// can be hashed while the probe engine walks the previous one.
// Reset clears the occupancy bits and the entry count; key and payload
// storage is not cleared.
module double_hash_table_insert_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dht_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output dht_pkg::rsp_type rsp_item
);
   import dht_pkg::*;

   push_type wr;
   job_type  pop_job;
   logic     pop;
   logic     q_empty;
   logic     q_full;

   dht_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .queue_full (q_full),
      .busy       (busy),
      .wr         (wr)
   );

   dht_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .pop     (pop),
      .pop_job (pop_job),
      .empty   (q_empty),
      .full    (q_full)
   );

   dht_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_job     (pop_job),
      .queue_empty (q_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== rtl/core/dht_queue.sv =====
module dht_queue (
   input  logic             clock,
   input  logic             reset,
   input  dht_pkg::push_type wr,
   input  logic             pop,
   output dht_pkg::job_type pop_job,
   output logic             empty,
   output logic             full
);
   import dht_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type              store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_job = store_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr.push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !wr.push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) store_ff[wr_ptr_ff] <= wr.job;
   end

endmodule

// ===== rtl/core/dht_front.sv =====
module dht_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dht_pkg::req_type  req_item,
   input  logic              queue_full,
   output logic              busy,
   output dht_pkg::push_type wr
);
   import dht_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_HASH = 2'b10
   } fstate_type;

   localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

   fstate_type        state_ff, state_in;
   logic [KEY_W-1:0]  rest_ff, rest_in;
   logic [SLOT_W-1:0] h_ff, h_in;
   logic [KEY_W-1:0]  key_ff;
   logic [PAY_W-1:0]  payload_ff;
   logic              accept;
   logic [62:0]       prod;
   logic [KEY_W-1:0]  quot;
   logic [KEY_W-1:0]  rem_full;

   assign busy   = (state_ff != F_IDLE) || queue_full;
   assign accept = start && !busy;

   // one decimal digit per cycle: divide by ten through the reciprocal
   assign prod     = 63'(rest_ff) * 63'(RECIP10);
   assign quot     = KEY_W'(prod[62:35]);
   assign rem_full = rest_ff - ((quot << 3) + (quot << 1));
   assign h_in     = mod_table(14'(h_ff) * 14'd11 + 14'(rem_full[3:0]));

   // classify and hash
   always_comb begin
      state_in   = state_ff;
      rest_in    = rest_ff;
      wr.push    = 1'b0;
      wr.job     = '0;
      case (state_ff)
         F_IDLE: begin
            wr.job.key     = req_item.key;
            wr.job.payload = req_item.payload;
            wr.job.slot    = req_item.slot_index;
            if (accept) begin
               if (req_item.action) begin
                  wr.push     = 1'b1;
                  wr.job.kind = (req_item.slot_index < SLOT_W'(TABLE_SIZE)) ?
                                KIND_READ : KIND_RANGE;
               end else if (req_item.key == '0) begin
                  wr.push     = 1'b1;
                  wr.job.kind = KIND_ZERO;
               end else begin
                  rest_in  = req_item.key;
                  state_in = F_HASH;
               end
            end
         end
         F_HASH: begin
            rest_in        = quot;
            wr.job.kind    = KIND_INSERT;
            wr.job.key     = key_ff;
            wr.job.payload = payload_ff;
            wr.job.slot    = h_in;
            if (quot == '0) begin
               wr.push  = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      if (accept) begin
         h_ff       <= '0;
         key_ff     <= req_item.key;
         payload_ff <= req_item.payload;
      end else if (state_ff == F_HASH) begin
         h_ff <= h_in;
      end
   end

endmodule

// ===== rtl/core/dht_back.sv =====
`include "assert_macros.svh"
module dht_back (
   input  logic             clock,
   input  logic             reset,
   input  dht_pkg::job_type pop_job,
   input  logic             queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   output dht_pkg::rsp_type rsp_item
);
   import dht_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_WAIT  = 3'b010,
      B_CHECK = 3'b100
   } bstate_type;

   bstate_type        state_ff, state_in;
   job_type           job_ff, job_in;
   logic [SLOT_W-1:0] addr_ff, addr_in;
   logic [SLOT_W-1:0] step_ff, step_in;
   logic [SLOT_W-1:0] tries_ff, tries_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              we;
   logic [SLOT_W:0]   pos_sum;
   logic [SLOT_W-1:0] next_pos;
   logic [IDX_W-1:0]  idx;

   logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
   logic [PAY_W-1:0]      pay_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [KEY_W-1:0]      key_q_ff;
   logic [PAY_W-1:0]      pay_q_ff;
   logic                  hit_q_ff;

   assign idx       = addr_ff[IDX_W-1:0];
   assign pos_sum   = {1'b0, addr_ff} + {1'b0, step_ff};
   assign next_pos  = (pos_sum >= (SLOT_W+1)'(TABLE_SIZE)) ?
                      SLOT_W'(pos_sum - (SLOT_W+1)'(TABLE_SIZE)) : pos_sum[SLOT_W-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // probe sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      addr_in      = addr_ff;
      step_in      = step_ff;
      tries_in     = tries_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      we           = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop                 = 1'b1;
               job_in              = pop_job;
               rsp_in.slot         = '0;
               rsp_in.read_key     = '0;
               rsp_in.read_payload = '0;
               rsp_in.entry_count  = count_ff;
               case (pop_job.kind)
                  KIND_ZERO: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STATUS_ZERO;
                  end
                  KIND_RANGE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STATUS_RANGE;
                     rsp_in.slot   = pop_job.slot;
                  end
                  KIND_READ: begin
                     addr_in  = pop_job.slot;
                     state_in = B_WAIT;
                  end
                  KIND_INSERT: begin
                     if (count_ff >= SLOT_W'(TABLE_SIZE)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        addr_in  = pop_job.slot;
                        step_in  = mod_step(14'(pop_job.slot) * 14'd17 + 14'd3) + 1'b1;
                        tries_in = '0;
                        state_in = B_WAIT;
                     end
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_WAIT: state_in = B_CHECK;
         B_CHECK: begin
            rsp_in.read_key     = '0;
            rsp_in.read_payload = '0;
            rsp_in.entry_count  = count_ff;
            rsp_in.slot         = addr_ff;
            if (job_ff.kind == KIND_READ) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_READ;
               if (hit_q_ff) begin
                  rsp_in.read_key     = key_q_ff;
                  rsp_in.read_payload = pay_q_ff;
               end
               state_in = B_IDLE;
            end else if (!hit_q_ff) begin
               we                 = 1'b1;
               count_in           = count_ff + 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STATUS_INSERTED;
               rsp_in.entry_count = count_in;
               state_in           = B_IDLE;
            end else if (tries_ff == SLOT_W'(TABLE_SIZE - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_FULL;
               rsp_in.slot   = '0;
               state_in      = B_IDLE;
            end else begin
               tries_in = tries_ff + 1'b1;
               addr_in  = next_pos;
               state_in = B_WAIT;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (we) valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      addr_ff  <= addr_in;
      step_ff  <= step_in;
      tries_ff <= tries_in;
      rsp_ff   <= rsp_in;
      hit_q_ff <= valid_ff[idx];
   end

   // table storage, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         key_mem[idx] <= job_ff.key;
         pay_mem[idx] <= job_ff.payload;
      end
      key_q_ff <= key_mem[idx];
      pay_q_ff <= pay_mem[idx];
   end

   `DHT_ASSERT(a_count_bound, clock, reset, count_ff <= SLOT_W'(TABLE_SIZE), "count overflow")
   `DHT_ASSERT_IMPL(a_write_empty, clock, reset, we, !hit_q_ff, "write to occupied slot")
   `DHT_ASSERT_IMPL(a_addr_range, clock, reset, state_ff == B_CHECK, addr_ff < SLOT_W'(TABLE_SIZE), "probe out of table")

endmodule
